// ===== design/glyph_bitmap_pixel_expander_assert.svh =====
// assertion macros used by the gbpe_serial module
`ifndef GLYPH_BITMAP_PIXEL_EXPANDER_ASSERT_SVH
`define GLYPH_BITMAP_PIXEL_EXPANDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GBPE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbpe assertion failed");

// next-cycle implication, checked out of reset
`define GBPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbpe assertion failed");

`endif

// ===== design/gbpe_pkg.sv =====
package gbpe_pkg;

    localparam int WORD_IDX_W = 5;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    localparam logic CFG_INK   = 1'b0;
    localparam logic CFG_PAPER = 1'b1;

    localparam logic [WORD_IDX_W-1:0] WORD_PAGE_CMD  = 5'd0;
    localparam logic [WORD_IDX_W-1:0] WORD_XS_HI     = 5'd1;
    localparam logic [WORD_IDX_W-1:0] WORD_XS_LO     = 5'd2;
    localparam logic [WORD_IDX_W-1:0] WORD_XE_HI     = 5'd3;
    localparam logic [WORD_IDX_W-1:0] WORD_XE_LO     = 5'd4;
    localparam logic [WORD_IDX_W-1:0] WORD_COL_CMD   = 5'd5;
    localparam logic [WORD_IDX_W-1:0] WORD_ROW_HI_A  = 5'd6;
    localparam logic [WORD_IDX_W-1:0] WORD_ROW_LO_A  = 5'd7;
    localparam logic [WORD_IDX_W-1:0] WORD_ROW_HI_B  = 5'd8;
    localparam logic [WORD_IDX_W-1:0] WORD_ROW_LO_B  = 5'd9;
    localparam logic [WORD_IDX_W-1:0] WORD_WRITE_CMD = 5'd10;
    localparam logic [WORD_IDX_W-1:0] WORD_PIX_FIRST = 5'd11;
    localparam logic [WORD_IDX_W-1:0] WORD_PIX_LAST  = 5'd18;

    typedef struct packed {
        logic [7:0]  bits;
        logic [15:0] x_start;
        logic [15:0] x_stop;
        logic [15:0] row;
    } job_t;

endpackage

// ===== design/gbpe_cursor.sv =====
module gbpe_cursor
    import gbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  bitmap_byte,
    input  logic        glyph_start,
    input  logic [15:0] origin_x,
    input  logic [15:0] origin_y,
    input  logic [3:0]  width_bytes,
    input  logic        job_take,
    output logic        job_valid,
    output job_t        job
);

    logic [15:0] glyph_left_reg,  glyph_left_next;
    logic [3:0]  glyph_width_reg, glyph_width_next;
    logic [15:0] x_start_reg,     x_start_next;
    logic [15:0] x_stop_reg,      x_stop_next;
    logic [15:0] row_reg,         row_next;
    logic        job_valid_reg;
    job_t        job_reg,         job_next;

    logic        accept;
    logic [15:0] cur_x_start;
    logic [15:0] cur_x_stop;
    logic [15:0] stop_step;
    logic [15:0] offset;
    logic        row_end;

    assign in_ready  = !job_valid_reg || job_take;
    assign accept    = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        if (glyph_start)
        begin
            glyph_left_next  = origin_x;
            glyph_width_next = width_bytes;
            cur_x_start      = origin_x;
            cur_x_stop       = origin_x + 16'd7;
            row_next         = origin_y;
        end
        else
        begin
            glyph_left_next  = glyph_left_reg;
            glyph_width_next = glyph_width_reg;
            cur_x_start      = x_start_reg;
            cur_x_stop       = x_stop_reg;
            row_next         = row_reg;
        end

        job_next.bits    = bitmap_byte;
        job_next.x_start = cur_x_start;
        job_next.x_stop  = cur_x_stop;
        job_next.row     = row_next;

        // step right by one byte, or back to the left edge on the next row
        stop_step = cur_x_stop + 16'd8;
        offset    = stop_step - glyph_left_next;
        row_end   = offset >= {9'd0, glyph_width_next, 3'b000};
        if (row_end)
        begin
            x_start_next = glyph_left_next;
            x_stop_next  = glyph_left_next + 16'd7;
        end
        else
        begin
            x_start_next = cur_x_stop + 16'd1;
            x_stop_next  = stop_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_left_reg  <= 16'd0;
            glyph_width_reg <= 4'd1;
            x_start_reg     <= 16'd0;
            x_stop_reg      <= 16'd7;
            row_reg         <= 16'd0;
            job_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            glyph_left_reg  <= glyph_left_next;
            glyph_width_reg <= glyph_width_next;
            x_start_reg     <= x_start_next;
            x_stop_reg      <= x_stop_next;
            row_reg         <= row_end ? row_next + 16'd1 : row_next;
            job_valid_reg   <= 1'b1;
        end
        else if (job_take)
        begin
            job_valid_reg   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== design/gbpe_serial.sv =====
`include "glyph_bitmap_pixel_expander_assert.svh"

module gbpe_serial
    import gbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    input  logic [15:0] ink_color,
    input  logic [15:0] paper_color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_command,
    output logic [15:0] bus_word,
    output logic        last_word
);

    logic [WORD_IDX_W-1:0] idx_reg;
    logic                  out_valid_reg;
    logic                  is_command_reg, is_command_next;
    logic [15:0]           bus_word_reg,   bus_word_next;
    logic                  last_word_reg,  last_word_next;

    logic                  out_load;
    logic                  advance;
    logic [2:0]            pix_sel;

    assign out_load   = !out_valid_reg || out_ready;
    assign advance    = job_valid && out_load;
    assign job_take   = advance && (idx_reg == WORD_PIX_LAST);
    assign out_valid  = out_valid_reg;
    assign is_command = is_command_reg;
    assign bus_word   = bus_word_reg;
    assign last_word  = last_word_reg;

    always_comb
    begin
        pix_sel         = 3'(idx_reg - WORD_PIX_FIRST);
        is_command_next = 1'b0;
        bus_word_next   = 16'd0;
        last_word_next  = 1'b0;
        unique case (idx_reg) inside
            WORD_PAGE_CMD:
            begin
                is_command_next = 1'b1;
                bus_word_next   = {8'd0, CMD_PAGE_ADDR};
            end
            WORD_XS_HI:    bus_word_next = {8'd0, job.x_start[15:8]};
            WORD_XS_LO:    bus_word_next = job.x_start;
            WORD_XE_HI:    bus_word_next = {8'd0, job.x_stop[15:8]};
            WORD_XE_LO:    bus_word_next = job.x_stop;
            WORD_COL_CMD:
            begin
                is_command_next = 1'b1;
                bus_word_next   = {8'd0, CMD_COL_ADDR};
            end
            WORD_ROW_HI_A, WORD_ROW_HI_B: bus_word_next = {8'd0, job.row[15:8]};
            WORD_ROW_LO_A, WORD_ROW_LO_B: bus_word_next = job.row;
            WORD_WRITE_CMD:
            begin
                is_command_next = 1'b1;
                bus_word_next   = {8'd0, CMD_MEM_WRITE};
            end
            [WORD_PIX_FIRST:WORD_PIX_LAST]:
            begin
                // msb first
                bus_word_next  = job.bits[3'd7 - pix_sel] ? ink_color : paper_color;
                last_word_next = (idx_reg == WORD_PIX_LAST);
            end
            default:
            begin
                bus_word_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= WORD_PAGE_CMD;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg       <= (idx_reg == WORD_PIX_LAST) ? WORD_PAGE_CMD
                                                        : idx_reg + 5'd1;
            out_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            is_command_reg <= is_command_next;
            bus_word_reg   <= bus_word_next;
            last_word_reg  <= last_word_next;
        end
    end

    `GBPE_ASSERT_NOW(a_idx_range, 1'b1, idx_reg <= WORD_PIX_LAST)
    `GBPE_ASSERT_NOW(a_last_is_data, out_valid_reg && last_word_reg, !is_command_reg)
    `GBPE_ASSERT_NOW(a_cmd_high_zero, out_valid_reg && is_command_reg, bus_word_reg[15:8] == 8'd0)
    `GBPE_ASSERT_NEXT(a_take_wraps, job_take, idx_reg == WORD_PAGE_CMD && last_word_reg)

endmodule

// ===== design/glyph_bitmap_pixel_expander.sv =====
// the first bus word of a byte passes through the cursor's job register and then the serial output register
// each byte becomes 19 bus words, one bus word per cycle on the output side while m_tready holds high
// the next byte is taken while the previous byte's last word still waits
// reset: cursor at x 0, row 0, glyph width one byte; ink 0x0000, paper 0xffff
// reset: no bus word pending and no byte held
module glyph_bitmap_pixel_expander
    import gbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bitmap_byte, origin_x, origin_y, width_bytes, zero pad
    input  logic        s_tuser,   // glyph_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // bus_word
    output logic        m_tuser,   // is_command
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] ink_reg;
    logic [15:0] paper_reg;
    logic        job_valid;
    logic        job_take;
    job_t        job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ink_reg   <= 16'h0000;
            paper_reg <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_INK)
            begin
                ink_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PAPER)
            begin
                paper_reg <= cfg_data;
            end
        end
    end

    gbpe_cursor u_cursor
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .bitmap_byte (s_tdata[7:0]),
        .glyph_start (s_tuser),
        .origin_x    (s_tdata[23:8]),
        .origin_y    (s_tdata[39:24]),
        .width_bytes (s_tdata[43:40]),
        .job_take    (job_take),
        .job_valid   (job_valid),
        .job         (job)
    );

    gbpe_serial u_serial
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take),
        .ink_color   (ink_reg),
        .paper_color (paper_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .is_command  (m_tuser),
        .bus_word    (m_tdata),
        .last_word   (m_tlast)
    );

endmodule
